>>> rtl/threshold_stage_sequencer_macros.svh
// Assertion macros shared by the threshold stage sequencer RTL.
`ifndef THRESHOLD_STAGE_SEQUENCER_MACROS_SVH
`define THRESHOLD_STAGE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

>>> rtl/tss_pkg.sv
// Types and constants of the threshold stage sequencer.
`default_nettype none

package tss_pkg;

    // Port widths of the stream channels.
    localparam int S_TDATA_W = 184;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // Width of the packed table words.
    localparam int TRG_W = 152;
    localparam int OUT_W = 64;

    // Milliseconds per second for the time trigger.
    localparam int MS_PER_S = 1000;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_START    = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;
    // Reserved code: changes nothing and only returns the status.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Stage field codes of a load transaction.
    localparam logic [3:0] FLD_NUMBER    = 4'd0;
    localparam logic [3:0] FLD_SECONDS   = 4'd1;
    localparam logic [3:0] FLD_TEMP_THR  = 4'd2;
    localparam logic [3:0] FLD_OD_THR1   = 4'd3;
    localparam logic [3:0] FLD_OD_THR6   = 4'd8;
    localparam logic [3:0] FLD_TEMP_GOAL = 4'd9;
    localparam logic [3:0] FLD_SENSOR    = 4'd10;
    localparam logic [3:0] FLD_OD_GOAL   = 4'd11;
    localparam logic [3:0] FLD_DRIFT     = 4'd12;
    localparam logic [3:0] FLD_NEXT      = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LD_WR,
        ST_SC_RD,
        ST_SC_EV,
        ST_FIN_RD,
        ST_FIN_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ld_rd;
        logic ld_wr;
        logic setup;
        logic sc_rd;
        logic sc_ev;
        logic fin_rd;
        logic out_load;
        logic latch_in;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       n_zero;
        logic       last;
        logic       fire;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/tss_ctrl.sv
// Controller state machine of the threshold stage sequencer.
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.op)
                    OP_LOAD: begin
                        cmd.ld_rd  = 1'b1;
                        state_next = ST_LD_WR;
                    end
                    OP_START: begin
                        cmd.latch_in = 1'b1;
                        state_next   = ST_FIN_RD;
                    end
                    OP_SAMPLE: begin
                        cmd.setup  = 1'b1;
                        state_next = sts.n_zero ? ST_FIN_RD : ST_SC_RD;
                    end
                    default: begin
                        state_next = ST_FIN_RD;
                    end
                endcase
            end
            ST_LD_WR: begin
                cmd.ld_wr  = 1'b1;
                state_next = ST_FIN_RD;
            end
            ST_SC_RD: begin
                cmd.sc_rd  = 1'b1;
                state_next = ST_SC_EV;
            end
            ST_SC_EV: begin
                cmd.sc_ev  = 1'b1;
                state_next = (sts.fire || sts.last) ? ST_FIN_RD : ST_SC_RD;
            end
            ST_FIN_RD: begin
                cmd.fin_rd = 1'b1;
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tss_datapath.sv
// Datapath of the threshold stage sequencer: stage table, latches, scan and output.
`default_nettype none

module tss_datapath
    import tss_pkg::*;
#(
    parameter int STAGES = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata,
    input  wire cmd_t                 cmd,
    output sts_t                      sts
);

    localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CNT_W = $clog2(STAGES + 1);
    localparam int LIM_W = 42;

    // Threshold crossing strictly since the latch.
    function automatic logic crossed(input logic [15:0] thr, input logic [15:0] now_v,
                                     input logic [15:0] then_v);
        crossed = ((now_v < thr) && (then_v > thr)) || ((now_v > thr) && (then_v < thr));
    endfunction

    // Captured input transaction.
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [1:0]           in_op_reg;
    logic [2:0]           f_idx;
    logic [3:0]           f_field;
    logic [31:0]          f_value;
    logic [31:0]          f_now;
    logic [15:0]          f_temp;
    logic [15:0]          f_od [6];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    assign f_idx   = in_data_reg[2:0];
    assign f_field = in_data_reg[6:3];
    assign f_value = in_data_reg[38:7];
    assign f_now   = in_data_reg[70:39];
    assign f_temp  = in_data_reg[86:71];
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            f_od[k] = in_data_reg[87 + 16*k +: 16];
        end
    end

    // Control state: count register, active stage, latches, scan counter.
    logic [3:0]       stage_count_reg;
    logic [IDX_W-1:0] active_reg;
    logic [31:0]      start_ms_reg;
    logic [15:0]      lat_temp_reg;
    logic [15:0]      lat_od_reg [6];
    logic [31:0]      elapsed_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             changed_reg;
    logic             fire;
    logic             do_latch;
    logic [IDX_W-1:0] idx_addr;
    logic [IDX_W-1:0] scan_addr;
    logic             in_range;

    assign idx_addr  = IDX_W'(f_idx);
    assign scan_addr = scan_reg[IDX_W-1:0];
    assign in_range  = 32'(f_idx) < STAGES;
    assign do_latch  = cmd.latch_in || (cmd.sc_ev && fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= '0;
            active_reg      <= '0;
            start_ms_reg    <= '0;
            lat_temp_reg    <= '0;
            for (int k = 0; k < 6; k++) begin
                lat_od_reg[k] <= '0;
            end
            changed_reg     <= 1'b0;
            scan_reg        <= '0;
            n_reg           <= '0;
        end else begin
            if (cfg_we) begin
                stage_count_reg <= cfg_wdata;
            end
            if (cmd.capture) begin
                changed_reg <= 1'b0;
            end
            if (cmd.setup) begin
                scan_reg <= '0;
                n_reg    <= (32'(stage_count_reg) > STAGES) ? CNT_W'(STAGES)
                                                            : CNT_W'(stage_count_reg);
            end
            if (cmd.sc_ev) begin
                if (fire) begin
                    active_reg  <= scan_addr;
                    changed_reg <= 1'b1;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (do_latch) begin
                start_ms_reg <= f_now;
                lat_temp_reg <= f_temp;
                for (int k = 0; k < 6; k++) begin
                    lat_od_reg[k] <= f_od[k];
                end
            end
        end
    end

    // Elapsed time of the sample, modulo 2^32.
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            elapsed_reg <= f_now - start_ms_reg;
        end
    end

    // Stage table: trigger words and output words, each with per-entry valid bits.
    logic              trg_re, out_re, trg_we, out_we;
    logic [IDX_W-1:0]  trg_raddr, out_raddr;
    logic [TRG_W-1:0]  trg_rdata, trg_old, trg_new;
    logic [OUT_W-1:0]  out_rdata, out_old, out_new;
    logic [STAGES-1:0] trg_vld_reg, out_vld_reg;
    logic              trg_rv_reg, out_rv_reg;

    assign trg_re    = cmd.ld_rd || cmd.sc_rd;
    assign trg_raddr = cmd.ld_rd ? idx_addr : scan_addr;
    assign out_re    = cmd.ld_rd || cmd.setup || cmd.fin_rd;
    assign out_raddr = cmd.ld_rd ? idx_addr : active_reg;
    assign trg_we    = cmd.ld_wr && in_range && (f_field <= FLD_OD_THR6);
    assign out_we    = cmd.ld_wr && in_range && (f_field >= FLD_TEMP_GOAL)
                       && (f_field <= FLD_NEXT);

    tss_ram #(.WIDTH(TRG_W), .DEPTH(STAGES)) u_trg_ram (
        .aclk  (aclk),
        .we    (trg_we),
        .waddr (idx_addr),
        .wdata (trg_new),
        .re    (trg_re),
        .raddr (trg_raddr),
        .rdata (trg_rdata)
    );

    tss_ram #(.WIDTH(OUT_W), .DEPTH(STAGES)) u_out_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (idx_addr),
        .wdata (out_new),
        .re    (out_re),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    // Valid bits: an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trg_vld_reg <= '0;
            out_vld_reg <= '0;
        end else begin
            if (trg_we) begin
                trg_vld_reg[idx_addr] <= 1'b1;
            end
            if (out_we) begin
                out_vld_reg[idx_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (trg_re) begin
            trg_rv_reg <= trg_vld_reg[trg_raddr];
        end
        if (out_re) begin
            out_rv_reg <= out_vld_reg[out_raddr];
        end
    end

    assign trg_old = trg_rv_reg ? trg_rdata : '0;
    assign out_old = out_rv_reg ? out_rdata : '0;

    // Merge one loaded field into the word read back from the table.
    always_comb begin
        trg_new = trg_old;
        out_new = out_old;
        case (f_field)
            FLD_NUMBER:    trg_new[7:0]   = f_value[7:0];
            FLD_SECONDS:   trg_new[39:8]  = f_value;
            FLD_TEMP_THR:  trg_new[55:40] = f_value[15:0];
            FLD_TEMP_GOAL: out_new[15:0]  = f_value[15:0];
            FLD_SENSOR:    out_new[23:16] = f_value[7:0];
            FLD_OD_GOAL:   out_new[39:24] = f_value[15:0];
            FLD_DRIFT:     out_new[55:40] = f_value[15:0];
            FLD_NEXT:      out_new[63:56] = f_value[7:0];
            default: begin
                for (int k = 0; k < 6; k++) begin
                    if (f_field == FLD_OD_THR1 + 4'(k)) begin
                        trg_new[56 + 16*k +: 16] = f_value[15:0];
                    end
                end
            end
        endcase
    end

    // Trigger evaluation of the scanned entry.
    logic [LIM_W-1:0] limit;
    logic             any_cross;

    assign limit = LIM_W'(trg_old[39:8]) * LIM_W'(MS_PER_S);

    always_comb begin
        any_cross = crossed(trg_old[55:40], f_temp, lat_temp_reg);
        for (int k = 0; k < 6; k++) begin
            any_cross = any_cross || crossed(trg_old[56 + 16*k +: 16], f_od[k], lat_od_reg[k]);
        end
    end

    // Fires on a number match if elapsed time > duration or a threshold is crossed.
    assign fire = (trg_old[7:0] == out_old[63:56])
                  && ((LIM_W'(elapsed_reg) > limit) || any_cross);

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {4'd0, out_old, 3'(active_reg), changed_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status back to the controller.
    assign sts.op       = in_op_reg;
    assign sts.n_zero   = (stage_count_reg == 4'd0);
    assign sts.last     = ({1'b0, scan_reg} + 1'b1) == {1'b0, n_reg};
    assign sts.fire     = fire;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

>>> rtl/threshold_stage_sequencer.sv
// Top level of the threshold stage sequencer.
//
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid/s_tready    one load, start or sample transaction
// m_        out        m_tvalid/m_tready    one status result per transaction
// cfg_      in         cfg_we               stage_count register
//
// After acceptance a load passes through ST_DISPATCH, ST_LD_WR, ST_FIN_RD and
// ST_FIN_OUT; a start or unknown op skips ST_LD_WR; a sample scans n stages,
// where n is the number scanned before a trigger fires (at most the smaller of
// stage_count and STAGES), each in a table read state and an evaluation state on the single read port.
// Reset is synchronous and active low and clears the table at once through
// valid bits. A held result in the output register does not block acceptance;
// the next result waits in ST_FIN_OUT until m_tready frees the register.
`default_nettype none
`include "threshold_stage_sequencer_macros.svh"

module threshold_stage_sequencer
    import tss_pkg::*;
#(
    parameter int STAGES = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata: stage_index, field_select, load_value, now_ms, temp_reading,
    // od_reading_1 .. od_reading_6
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: op
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // m_tdata: stage_changed, current_stage, temp_target, od_sensor_choice,
    // od_target, od_drift, next_stage_number
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    tss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tss_datapath #(.STAGES(STAGES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // One transaction at a time: no acceptance right after one.
    `TSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // A result is never loaded over one that is still waiting.
    `TSS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready)
    // A firing stage ends the scan.
    `TSS_ASSERT_NEXT(a_fire_ends_scan, cmd.sc_ev && sts.fire, cmd.fin_rd)

endmodule

`default_nettype wire

>>> verif/tb_threshold_stage_sequencer.sv
// Self-checking testbench for the threshold stage sequencer stream block.
`timescale 1ns / 100ps

module tb_threshold_stage_sequencer;
    import tss_pkg::*;

    localparam int NSTG = 8;
    localparam int STALL_LIMIT = 6000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE = 40;

    // Input fields of one transaction, first field in the lowest bits.
    typedef struct packed {
        logic [15:0] od6;
        logic [15:0] od5;
        logic [15:0] od4;
        logic [15:0] od3;
        logic [15:0] od2;
        logic [15:0] od1;
        logic [15:0] temp;
        logic [31:0] now_ms;
        logic [31:0] value;
        logic [3:0]  field;
        logic [2:0]  index;
    } item_t;

    // Result fields, first field in the lowest bits.
    typedef struct packed {
        logic [7:0]  next_num;
        logic [15:0] drift;
        logic [15:0] od_goal;
        logic [7:0]  sensor;
        logic [15:0] temp_goal;
        logic [2:0]  cur;
        logic        changed;
    } status_t;

    // Scoreboard: mirrors the stage table and keeps the expected status results.
    class stage_scoreboard;
        logic [7:0]  number   [NSTG];
        logic [31:0] seconds  [NSTG];
        logic [15:0] temp_thr [NSTG];
        logic [15:0] od_thr   [NSTG][6];
        logic [15:0] temp_goal[NSTG];
        logic [7:0]  sensor   [NSTG];
        logic [15:0] od_goal  [NSTG];
        logic [15:0] drift    [NSTG];
        logic [7:0]  next_num [NSTG];
        logic [2:0]  active;
        logic [31:0] start_ms;
        logic [15:0] held_temp;
        logic [15:0] held_od  [6];
        logic [3:0]  count;
        status_t     pending_status[$];
        int          errors;
        int          checked;
        int          changes;

        function new();
            for (int i = 0; i < NSTG; i++) begin
                number[i] = 0; seconds[i] = 0; temp_thr[i] = 0; temp_goal[i] = 0;
                sensor[i] = 0; od_goal[i] = 0; drift[i] = 0; next_num[i] = 0;
                for (int k = 0; k < 6; k++) od_thr[i][k] = 0;
            end
            for (int k = 0; k < 6; k++) held_od[k] = 0;
            active = 0; start_ms = 0; held_temp = 0; count = 0;
            errors = 0; checked = 0; changes = 0;
        endfunction

        function automatic bit crossed(logic [15:0] thr, logic [15:0] now, logic [15:0] was);
            return (now < thr && was > thr) || (now > thr && was < thr);
        endfunction

        function automatic logic [15:0] od_of(item_t it, int k);
            logic [95:0] all;
            all = {it.od6, it.od5, it.od4, it.od3, it.od2, it.od1};
            return all[k*16 +: 16];
        endfunction

        function automatic void capture(item_t it);
            start_ms = it.now_ms;
            held_temp = it.temp;
            for (int k = 0; k < 6; k++) held_od[k] = od_of(it, k);
        endfunction

        function automatic bit triggers(int i, item_t it);
            logic [31:0] elapsed;
            logic [63:0] span;
            elapsed = it.now_ms - start_ms;
            span = {32'd0, seconds[i]} * 64'd1000;
            if (span > {32'd0, elapsed}) begin
            end else if (span < {32'd0, elapsed}) begin
                return 1;
            end
            if (crossed(temp_thr[i], it.temp, held_temp)) return 1;
            for (int k = 0; k < 6; k++)
                if (crossed(od_thr[i][k], od_of(it, k), held_od[k])) return 1;
            return 0;
        endfunction

        // Apply an accepted input transaction and queue its status result.
        function automatic void note_input(logic [1:0] op, item_t it);
            status_t s;
            int n;
            logic [7:0] want;
            s.changed = 0;
            if (op == OP_LOAD) begin
                case (it.field)
                    FLD_NUMBER:    number[it.index] = it.value[7:0];
                    FLD_SECONDS:   seconds[it.index] = it.value;
                    FLD_TEMP_THR:  temp_thr[it.index] = it.value[15:0];
                    FLD_TEMP_GOAL: temp_goal[it.index] = it.value[15:0];
                    FLD_SENSOR:    sensor[it.index] = it.value[7:0];
                    FLD_OD_GOAL:   od_goal[it.index] = it.value[15:0];
                    FLD_DRIFT:     drift[it.index] = it.value[15:0];
                    FLD_NEXT:      next_num[it.index] = it.value[7:0];
                    default:
                        if (it.field >= FLD_OD_THR1 && it.field <= FLD_OD_THR6)
                            od_thr[it.index][it.field - FLD_OD_THR1] = it.value[15:0];
                endcase
            end else if (op == OP_START) begin
                capture(it);
            end else if (op == OP_SAMPLE) begin
                n = (count > NSTG) ? NSTG : count;
                want = next_num[active];
                for (int i = 0; i < n; i++) begin
                    if (number[i] == want && triggers(i, it)) begin
                        active = i;
                        s.changed = 1;
                        capture(it);
                        changes++;
                        break;
                    end
                end
            end
            s.cur = active;
            s.temp_goal = temp_goal[active];
            s.sensor = sensor[active];
            s.od_goal = od_goal[active];
            s.drift = drift[active];
            s.next_num = next_num[active];
            pending_status.push_back(s);
        endfunction

        task automatic report(string what, logic [31:0] got, logic [31:0] exp);
            errors++;
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
        endtask

        // Compare one accepted result with the oldest expectation.
        task automatic check_result(status_t got);
            status_t e;
            checked++;
            if (pending_status.size() == 0) begin
                report("unexpected result", got[31:0], 0);
                return;
            end
            e = pending_status.pop_front();
            if (got.changed !== e.changed) report("stage_changed", got.changed, e.changed);
            if (got.cur !== e.cur) report("current_stage", got.cur, e.cur);
            if (got.temp_goal !== e.temp_goal) report("temp_target", got.temp_goal, e.temp_goal);
            if (got.sensor !== e.sensor) report("od_sensor_choice", got.sensor, e.sensor);
            if (got.od_goal !== e.od_goal) report("od_target", got.od_goal, e.od_goal);
            if (got.drift !== e.drift) report("od_drift", got.drift, e.drift);
            if (got.next_num !== e.next_num) report("next_stage_number", got.next_num, e.next_num);
        endtask
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic                 cfg_we = 0;
    logic [3:0]           cfg_wdata = '0;

    stage_scoreboard sb = new();
    bit  steady_flow = 0;
    bit  long_hold_req = 0;
    int  idle_cycles = 0;
    int  items_sent = 0;
    logic [31:0] clock_ms = 0;

    always #6 aclk = ~aclk;

    threshold_stage_sequencer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_tready <= 0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 0;
            end
            gap = steady_flow ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(status_t'(m_tdata[67:0]));
        end
    end

    // Offer one transaction after a random gap and wait for its acceptance.
    task automatic send(logic [1:0] op, item_t it);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {1'b0, it};
        s_tuser <= op;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, it);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_status.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write the stage count only with the block idle.
    task automatic set_count(logic [3:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.count = v;
    endtask

    function automatic logic [15:0] reading();
        return ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    endfunction

    function automatic item_t sample_item();
        item_t it;
        it = item_t'(183'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(0, 19) == 0) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 2500);
        end
        it.now_ms = clock_ms;
        it.temp = reading();
        it.od1 = reading(); it.od2 = reading(); it.od3 = reading();
        it.od4 = reading(); it.od5 = reading(); it.od6 = reading();
        return it;
    endfunction

    function automatic item_t load_item(logic [2:0] idx, logic [3:0] fld, logic [31:0] v);
        item_t it;
        it = item_t'(183'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        it.index = idx;
        it.field = fld;
        it.value = v;
        return it;
    endfunction

    // Field value biased toward small numbers so that chains and triggers meet.
    function automatic logic [31:0] field_value(logic [3:0] fld);
        if ($urandom_range(0, 9) == 0) return $urandom;
        if (fld == FLD_NUMBER || fld == FLD_NEXT) return $urandom_range(0, 3);
        if (fld == FLD_SECONDS) return $urandom_range(0, 3);
        return $urandom_range(0, 40);
    endfunction

    initial begin
        item_t it;
        int pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: empty table, every field, extremes, odd ops and indexes.
        set_count(4'd0);
        send(OP_SAMPLE, sample_item());
        for (int f = 0; f < 16; f++) send(OP_LOAD, load_item(3'd7, 4'(f), 32'hFFFF_FFFF));
        for (int f = 0; f < 16; f++) begin
            if (f % 3 == 0) send(OP_LOAD, load_item(3'd0, 4'(f), 32'd0));
        end
        send(OP_RESERVED, sample_item());
        set_count(4'd15);
        it = sample_item();
        send(OP_START, it);
        it.now_ms = it.now_ms + 32'd5;
        send(OP_SAMPLE, it);
        it.now_ms = 32'hFFFF_FFFF;
        send(OP_SAMPLE, it);
        set_count(4'd8);
        send(OP_SAMPLE, sample_item());

        // Random phases: build a table, start, then mostly samples.
        for (int ph = 0; ph < 14; ph++) begin
            pick = $urandom_range(0, 5);
            set_count(pick == 0 ? 4'($urandom_range(9, 15)) :
                      pick == 1 ? 4'($urandom_range(0, 2)) :
                      pick < 4 ? 4'd8 : 4'($urandom_range(0, 8)));
            steady_flow = (ph % 4 == 1);
            if (ph == 3) long_hold_req = 1;
            for (int j = 0; j < 20; j++) begin
                logic [3:0] fld;
                fld = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                                   : 4'($urandom_range(0, 13));
                send(OP_LOAD, load_item(3'($urandom), fld, field_value(fld)));
            end
            send(OP_START, sample_item());
            for (int j = 0; j < 40; j++) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    send(OP_SAMPLE, sample_item());
                end else if (pick < 17) begin
                    logic [3:0] fld;
                    fld = 4'($urandom);
                    send(OP_LOAD, load_item(3'($urandom), fld, field_value(fld)));
                end else if (pick < 19) begin
                    send(OP_START, sample_item());
                end else begin
                    send(OP_RESERVED, sample_item());
                end
            end
        end

        steady_flow = 0;
        drain();
        $display("Sent %0d transactions over 14 table phases; %0d results checked, %0d stage changes.",
                 items_sent, sb.checked, sb.changes);
        if (sb.errors == 0 && sb.pending_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
